// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for clocked implications with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/e2cal_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_pkg
// Shared types, constants and calendar helpers for the epoch converter.
// ----------------------------------------------------------------------------
package e2cal_pkg;

    // x / 60 == (x * RECIP60) >> 37, exact for x < 2^32
    localparam logic [31:0] RECIP60       = 32'h8888_8889;
    // x / 3 == (x * RECIP3) >> 19, exact for x < 2^19
    localparam logic [17:0] RECIP3        = 18'd174763;
    // rough days / 365.25, scaled by 2^20; off by at most one year
    localparam logic [11:0] RECIP_YEAR    = 12'd2871;
    localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
    // year index of 2100, the only non-leap century in range
    localparam logic [7:0]  CENTURY_IDX   = 8'd130;
    localparam int          NUM_MONTHS    = 12;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } tod_t;

    typedef struct packed {
        logic [15:0] days;
        logic [7:0]  est;
        tod_t        tod;
    } split_t;

    typedef struct packed {
        logic [7:0] idx;
        logic [8:0] doy;
        logic       leap;
        tod_t       tod;
    } yday_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        tod_t        tod;
    } cal_t;

    // first day number of year 1970 + idx, for idx up to 137
    function automatic logic [15:0] year_start(input logic [7:0] idx);
        logic [16:0] acc;
        logic [8:0]  idx_p1;
        idx_p1 = {1'b0, idx} + 9'd1;
        acc = 17'(idx) * 17'd365;
        acc = acc + 17'(idx_p1[8:2]);
        if (idx > CENTURY_IDX)
        begin
            acc = acc - 17'd1;
        end
        return acc[15:0];
    endfunction

    function automatic logic is_leap_idx(input logic [7:0] idx);
        return (idx[1:0] == 2'b10) && (idx != CENTURY_IDX);
    endfunction

    // day of year on which month m0 (0 = January) starts
    function automatic logic [8:0] month_start(input logic [3:0] m0, input logic leap);
        logic [8:0] base;
        case (m0)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd0;
        endcase
        if (leap && (m0 >= 4'd2))
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_calendar_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into
// Gregorian year, month, day, hour, minute and second.
//
//   channel   handshake                  word
//   epoch     epoch_valid / epoch_ready  epoch_seconds
//   cal       cal_valid / cal_ready      year, month, day_of_month,
//                                        hour, minute, second
//
// Eight register stages: four for the time split, two for the year, two for
// the month. One word enters per cycle while epoch_ready is high.
// Reset clears all stage valid bits; the data registers are not reset.
// A stall on cal holds the output; bubbles in the pipe still fill, so
// epoch_ready stays high as long as any stage is empty.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top
    import e2cal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        epoch_valid,
    output logic        epoch_ready,
    input  logic [31:0] epoch_seconds,
    output logic        cal_valid,
    input  logic        cal_ready,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second
);

    logic   split_valid, split_ready;
    split_t split_word;
    logic   yday_valid, yday_ready;
    yday_t  yday_word;
    cal_t   cal_word;

    e2cal_time_split u_split (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (epoch_valid),
        .in_ready      (epoch_ready),
        .epoch_seconds (epoch_seconds),
        .out_valid     (split_valid),
        .out_ready     (split_ready),
        .out_word      (split_word)
    );

    e2cal_year_find u_year (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_word   (split_word),
        .out_valid (yday_valid),
        .out_ready (yday_ready),
        .out_word  (yday_word)
    );

    e2cal_month_find u_month (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yday_valid),
        .in_ready  (yday_ready),
        .in_word   (yday_word),
        .out_valid (cal_valid),
        .out_ready (cal_ready),
        .out_word  (cal_word)
    );

    assign year         = cal_word.year;
    assign month        = cal_word.month;
    assign day_of_month = cal_word.day;
    assign hour         = cal_word.tod.hour;
    assign minute       = cal_word.tod.minute;
    assign second       = cal_word.tod.second;

endmodule

// ----- rtl/e2cal_time_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_time_split
// Four-stage split of a second count into days, hours, minutes, seconds,
// plus a first estimate of the year index.
// ----------------------------------------------------------------------------
module e2cal_time_split
    import e2cal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output split_t      out_word
);

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic        en1, en2, en3, en4;

    logic [31:0] s1_t_reg;
    logic [26:0] s1_mins_reg;
    logic [26:0] s2_mins_reg;
    logic [20:0] s2_hours_reg;
    logic [5:0]  s2_sec_reg;
    logic [20:0] s3_hours_reg;
    logic [15:0] s3_days_reg;
    logic [5:0]  s3_min_reg;
    logic [5:0]  s3_sec_reg;
    split_t      s4_word_reg;

    logic [63:0] mins_prod;
    logic [26:0] mins_next;
    logic [32:0] mins_x60;
    logic [58:0] hours_prod;
    logic [20:0] hours_next;
    logic [5:0]  sec_next;
    logic [26:0] hours_x60;
    logic [35:0] days_prod;
    logic [15:0] days_next;
    logic [5:0]  min_next;
    logic [20:0] days_x24;
    logic [27:0] est_prod;
    split_t      s4_word_next;

    assign en4      = !s4_valid_reg || out_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        mins_prod  = 64'(epoch_seconds) * 64'(RECIP60);
        mins_next  = mins_prod[63:37];

        mins_x60   = {s1_mins_reg, 6'd0} - {4'd0, s1_mins_reg, 2'd0};
        sec_next   = s1_t_reg[5:0] - mins_x60[5:0];
        hours_prod = 59'(s1_mins_reg) * 59'(RECIP60);
        hours_next = hours_prod[57:37];

        hours_x60  = {s2_hours_reg, 6'd0} - {4'd0, s2_hours_reg, 2'd0};
        min_next   = s2_mins_reg[5:0] - hours_x60[5:0];
        days_prod  = 36'(s2_hours_reg[20:3]) * 36'(RECIP3);
        days_next  = days_prod[34:19];

        days_x24   = {1'b0, s3_days_reg, 4'd0} + {2'd0, s3_days_reg, 3'd0};
        est_prod   = 28'(s3_days_reg) * 28'(RECIP_YEAR);
        s4_word_next.days       = s3_days_reg;
        s4_word_next.est        = est_prod[27:20];
        s4_word_next.tod.hour   = s3_hours_reg[4:0] - days_x24[4:0];
        s4_word_next.tod.minute = s3_min_reg;
        s4_word_next.tod.second = s3_sec_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_t_reg    <= epoch_seconds;
            s1_mins_reg <= mins_next;
        end
        if (en2)
        begin
            s2_mins_reg  <= s1_mins_reg;
            s2_hours_reg <= hours_next;
            s2_sec_reg   <= sec_next;
        end
        if (en3)
        begin
            s3_hours_reg <= s2_hours_reg;
            s3_days_reg  <= days_next;
            s3_min_reg   <= min_next;
            s3_sec_reg   <= s2_sec_reg;
        end
        if (en4)
        begin
            s4_word_reg <= s4_word_next;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_word  = s4_word_reg;

endmodule

// ----- rtl/e2cal_year_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_year_find
// Two-stage year resolve: checks the estimate and its neighbors against
// year start days and leaves the day of year and leap flag.
// ----------------------------------------------------------------------------
module e2cal_year_find
    import e2cal_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  split_t in_word,
    output logic   out_valid,
    input  logic   out_ready,
    output yday_t  out_word
);

    logic        y1_valid_reg, y2_valid_reg;
    logic        en1, en2;

    logic [15:0] y1_days_reg;
    logic [7:0]  y1_lo_reg;
    logic [7:0]  y1_est_reg;
    logic [15:0] y1_st_lo_reg;
    logic [15:0] y1_st_mid_reg;
    logic [15:0] y1_st_hi_reg;
    tod_t        y1_tod_reg;
    yday_t       y2_word_reg;

    logic [7:0]  lo_next;
    logic [7:0]  sel_idx;
    logic [15:0] sel_base;
    logic [15:0] doy_full;
    yday_t       y2_word_next;

    assign en2      = !y2_valid_reg || out_ready;
    assign en1      = !y1_valid_reg || en2;
    assign in_ready = en1;

    // the estimate may be one year high or low
    always_comb
    begin
        lo_next = (in_word.est == 8'd0) ? 8'd0 : in_word.est - 8'd1;

        if (y1_days_reg >= y1_st_hi_reg)
        begin
            sel_idx  = y1_est_reg + 8'd1;
            sel_base = y1_st_hi_reg;
        end
        else if (y1_days_reg >= y1_st_mid_reg)
        begin
            sel_idx  = y1_est_reg;
            sel_base = y1_st_mid_reg;
        end
        else
        begin
            sel_idx  = y1_lo_reg;
            sel_base = y1_st_lo_reg;
        end
        doy_full          = y1_days_reg - sel_base;
        y2_word_next.idx  = sel_idx;
        y2_word_next.doy  = doy_full[8:0];
        y2_word_next.leap = is_leap_idx(sel_idx);
        y2_word_next.tod  = y1_tod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_valid_reg <= 1'b0;
            y2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) y1_valid_reg <= in_valid;
            if (en2) y2_valid_reg <= y1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            y1_days_reg   <= in_word.days;
            y1_est_reg    <= in_word.est;
            y1_lo_reg     <= lo_next;
            y1_st_lo_reg  <= year_start(lo_next);
            y1_st_mid_reg <= year_start(in_word.est);
            y1_st_hi_reg  <= year_start(in_word.est + 8'd1);
            y1_tod_reg    <= in_word.tod;
        end
        if (en2)
        begin
            y2_word_reg <= y2_word_next;
        end
    end

    assign out_valid = y2_valid_reg;
    assign out_word  = y2_word_reg;

endmodule

// ----- rtl/e2cal_month_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_month_find
// Two-stage month resolve: compares the day of year with every month start
// after January, then forms month, day of month and full year.
// ----------------------------------------------------------------------------
module e2cal_month_find
    import e2cal_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  yday_t in_word,
    output logic  out_valid,
    input  logic  out_ready,
    output cal_t  out_word
);

    logic        m1_valid_reg, m2_valid_reg;
    logic        en1, en2;

    logic [3:0]  m1_mon_reg;
    yday_t       m1_word_reg;
    cal_t        m2_word_reg;

    logic [3:0]  mon_next;
    logic [8:0]  day_off;
    cal_t        m2_word_next;

    assign en2      = !m2_valid_reg || out_ready;
    assign en1      = !m1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        mon_next = 4'd0;
        for (int m = 1; m < NUM_MONTHS; m++)
        begin
            if (in_word.doy >= month_start(4'(m), in_word.leap))
            begin
                mon_next = mon_next + 4'd1;
            end
        end

        day_off            = m1_word_reg.doy - month_start(m1_mon_reg, m1_word_reg.leap);
        m2_word_next.year  = EPOCH_YEAR + 12'(m1_word_reg.idx);
        m2_word_next.month = m1_mon_reg + 4'd1;
        m2_word_next.day   = day_off[4:0] + 5'd1;
        m2_word_next.tod   = m1_word_reg.tod;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) m1_valid_reg <= in_valid;
            if (en2) m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            m1_mon_reg  <= mon_next;
            m1_word_reg <= in_word;
        end
        if (en2)
        begin
            m2_word_reg <= m2_word_next;
        end
    end

    assign out_valid = m2_valid_reg;
    assign out_word  = m2_word_reg;

endmodule

// ----- rtl/e2cal_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2cal_checker
// Port-level checks for the epoch converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module e2cal_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        epoch_valid,
    input logic        epoch_ready,
    input logic        cal_valid,
    input logic        cal_ready,
    input logic [11:0] year,
    input logic [3:0]  month,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hour,
    input logic [5:0]  minute,
    input logic [5:0]  second
);

    logic in_fire;

    assign in_fire = epoch_valid && epoch_ready;

    `ASSERT_NXT(a_out_hold, clk, rst_n, cal_valid && !cal_ready,
        cal_valid && $stable(year) && $stable(month) && $stable(day_of_month)
        && $stable(hour) && $stable(minute) && $stable(second),
        "stalled calendar word changed")

    `ASSERT_IMP(a_ready_when_empty, clk, rst_n, !cal_valid || in_fire, epoch_ready,
        "input stalled with empty output stage")

    `ASSERT_IMP(a_field_range, clk, rst_n, cal_valid,
        year >= 12'd1970 && year <= 12'd2106 && month >= 4'd1 && month <= 4'd12
        && day_of_month >= 5'd1 && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59,
        "calendar field out of range")

    `ASSERT_IMP(a_month_len, clk, rst_n, cal_valid,
        (month != 4'd2 || day_of_month <= 5'd29)
        && ((month != 4'd4 && month != 4'd6 && month != 4'd9 && month != 4'd11)
            || day_of_month <= 5'd30),
        "day beyond end of month")

endmodule

bind epoch_seconds_to_calendar_top e2cal_checker u_e2cal_checker (.*);
